// File: design/sha_pkg.sv
package sha_pkg;

  // One input item: a message byte and its end-of-message mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } msg_item_t;

  // One result item: one word of the digest.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_item_t;

  localparam int unsigned BlockBits = 512;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned HashWords = 8;
  localparam int unsigned Rounds    = 64;
  localparam int unsigned CountBits = 61;

  localparam logic [7:0] PadMarker = 8'h80;

  localparam logic [31:0] InitHash [0:HashWords-1] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [0:Rounds-1] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (WordBits - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] v);
    big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] v);
    big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] v);
    small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] v);
    small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

// File: design/sha256_hash_unit.sv
// Channel | Dir | Handshake            | Payload
// msg     | in  | msg_valid/msg_stall  | msg_item_t: data_byte, has_byte, last
// dig     | out | dig_valid/dig_stall  | dig_item_t: digest_word, word_index, last_word
//
// Message bytes are taken while the block is idle; a full 64-byte block then holds
// the input while the shared round unit runs the rounds and the fold adds into the chain.
// A last item adds 9..72 pad bytes (one pad byte per cycle on the byte path), one or
// two padding compressions and eight result items.
// Reset is synchronous; an item can be taken at the first edge after reset drops.
// msg_stall is high while a block or a digest is in flight; dig_stall holds a word.
module sha256_hash_unit
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  output logic      msg_stall,
  input  msg_item_t msg,
  output logic      dig_valid,
  input  logic      dig_stall,
  output dig_item_t dig
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_ADD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;

  // Block under construction; bytes shift in at the low end, so word 0 of the
  // block sits in the top 32 bits once 64 bytes are in. During the rounds the
  // same register acts as the 16-word schedule window.
  logic [BlockBits-1:0] blk;
  logic [5:0]           byte_in_block;
  logic [CountBits-1:0] message_bytes;
  logic [31:0]          chain_value [0:HashWords-1];
  logic [31:0]          work [0:HashWords-1];
  logic [5:0]           rnd;
  logic [2:0]           out_idx;

  // Padding control: pad_mode marks an ended message still being padded,
  // sent_marker the 0x80 byte, wrap_pend a marker that left no room for the
  // length, finishing the compression of the final block.
  logic pad_mode;
  logic sent_marker;
  logic wrap_pend;
  logic finishing;

  logic                 push;
  logic [7:0]           push_byte;
  logic                 block_full;
  logic                 len_phase;
  logic [63:0]          len_bits;
  logic [7:0]           len_byte;
  logic [7:0]           pad_byte;
  logic                 in_take;

  logic [31:0] w0;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] choose;
  logic [31:0] major;

  assign msg_stall = (state != S_IDLE);
  assign in_take   = msg_valid && !msg_stall;

  // Bit length as 64 bits, big-endian; length byte j sits at bits 63-8j.
  assign len_bits  = {message_bytes, 3'b000};
  assign len_byte  = len_bits[{~byte_in_block[2:0], 3'b000} +: 8];
  assign len_phase = sent_marker && !wrap_pend && (byte_in_block[5:3] == 3'b111);

  always_comb begin
    if (!sent_marker) begin
      pad_byte = PadMarker;
    end else if (len_phase) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Shared byte path: message bytes in idle, pad bytes while padding.
  always_comb begin
    push      = 1'b0;
    push_byte = msg.data_byte;
    unique case (state)
      S_IDLE: begin
        push = in_take && msg.has_byte;
      end
      S_PAD: begin
        push      = 1'b1;
        push_byte = pad_byte;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign block_full = push && (byte_in_block == 6'd63);

  // One SHA-256 round per cycle and one new schedule word per cycle.
  assign w0     = blk[BlockBits-1 -: WordBits];
  assign w_new  = small_sigma1(blk[BlockBits-1-14*WordBits -: WordBits])
                + blk[BlockBits-1-9*WordBits -: WordBits]
                + small_sigma0(blk[BlockBits-1-WordBits -: WordBits])
                + w0;
  assign choose = (work[4] & work[5]) ^ (~work[4] & work[6]);
  assign major  = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign t1     = work[7] + big_sigma1(work[4]) + choose + RoundK[rnd] + w0;
  assign t2     = big_sigma0(work[0]) + major;

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (push) begin
      blk <= {blk[BlockBits-ByteBits-1:0], push_byte};
    end else if (state == S_ROUND) begin
      blk <= {blk[BlockBits-WordBits-1:0], w_new};
    end
    if (block_full) begin
      for (int i = 0; i < HashWords; i++) begin
        work[i] <= chain_value[i];
      end
    end else if (state == S_ROUND) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      byte_in_block <= '0;
      message_bytes <= '0;
      rnd           <= '0;
      out_idx       <= '0;
      pad_mode      <= 1'b0;
      sent_marker   <= 1'b0;
      wrap_pend     <= 1'b0;
      finishing     <= 1'b0;
      for (int i = 0; i < HashWords; i++) begin
        chain_value[i] <= InitHash[i];
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (msg.has_byte) begin
              byte_in_block <= byte_in_block + 6'd1;
              message_bytes <= message_bytes + {{(CountBits-1){1'b0}}, 1'b1};
            end
            if (block_full) begin
              state    <= S_ROUND;
              rnd      <= '0;
              pad_mode <= msg.last;
            end else if (msg.last) begin
              state    <= S_PAD;
              pad_mode <= 1'b1;
            end
          end
        end
        S_PAD: begin
          byte_in_block <= byte_in_block + 6'd1;
          if (!sent_marker) begin
            sent_marker <= 1'b1;
            // Marker in the last eight positions: length goes to a second block.
            if (byte_in_block[5:3] == 3'b111) begin
              wrap_pend <= 1'b1;
            end
          end
          if (block_full) begin
            state     <= S_ROUND;
            rnd       <= '0;
            wrap_pend <= 1'b0;
            finishing <= len_phase;
          end
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'(Rounds - 1)) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < HashWords; i++) begin
            chain_value[i] <= chain_value[i] + work[i];
          end
          if (finishing) begin
            state   <= S_OUT;
            out_idx <= '0;
          end else if (pad_mode) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!dig_stall) begin
            if (out_idx == 3'(HashWords - 1)) begin
              // Drop back to the initial hash for the next message.
              state         <= S_IDLE;
              byte_in_block <= '0;
              message_bytes <= '0;
              pad_mode      <= 1'b0;
              sent_marker   <= 1'b0;
              wrap_pend     <= 1'b0;
              finishing     <= 1'b0;
              for (int i = 0; i < HashWords; i++) begin
                chain_value[i] <= InitHash[i];
              end
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Digest words come straight from the chaining value, which holds in S_OUT.
  assign dig_valid       = (state == S_OUT);
  assign dig.digest_word = chain_value[out_idx];
  assign dig.word_index  = out_idx;
  assign dig.last_word   = (out_idx == 3'(HashWords - 1));

endmodule

// File: bench/sha256_hash_unit_tb.sv
`timescale 1ns / 100ps

module sha256_hash_unit_tb
  import sha_pkg::*;
();

  localparam int unsigned IDLE_LIMIT = 4000;  // cycles with no item moving on either side
  localparam int unsigned TAIL_CYCLES = 200;  // quiet time after the last digest word
  localparam int unsigned ITEM_TARGET = 320;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_FIELD_POS = 6'd56;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One entry of the send queue: the item and whether the sender must wait
  // for every outstanding digest word before offering it.
  typedef struct {
    msg_item_t item;
    bit        drain;
  } send_entry_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      msg_valid = 1'b0;
  logic      msg_stall;
  msg_item_t msg = '0;
  logic      dig_valid;
  logic      dig_stall = 1'b0;
  dig_item_t dig;

  sha256_hash_unit dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

  always #4 clk = ~clk;

  // Predicted hash state: chaining value, block buffer, fill position and
  // running byte count of the current message.
  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [5:0]  fill;
  logic [60:0] msg_len;

  dig_item_t   digest_q [$];   // digest words still owed by the block
  send_entry_t pending [$];    // items not yet offered to the block

  // Handshake flags, sampled at the rising edge and used at the falling edge.
  logic msg_took = 1'b0;
  logic dig_took = 1'b0;

  int unsigned fault_count = 0;
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned msgs_hashed = 0;
  int unsigned bytes_hashed = 0;
  int unsigned two_block_pads = 0;
  int unsigned words_checked = 0;
  int unsigned idle_cycles = 0;

  task automatic report_fault(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fault_count++;
  endtask

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
    logic [63:0] twice;
    twice = {v, v} >> n;
    return twice[31:0];
  endfunction

  // Run the 64 rounds over the buffered block and fold into the chain.
  task automatic fold_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 64; j++) begin
      w[j] = (ror(w[j-2], 17) ^ ror(w[j-2], 19) ^ (w[j-2] >> 10)) + w[j-7]
           + (ror(w[j-15], 7) ^ ror(w[j-15], 18) ^ (w[j-15] >> 3)) + w[j-16];
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int j = 0; j < 64; j++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[j] + w[j];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  // Drop a byte into the block big-endian; compress once the block is full.
  task automatic place_byte(input logic [7:0] value);
    blk[fill[5:2]][8*(3 - fill[1:0]) +: 8] = value;
    fill = fill + 6'd1;
    if (fill == 6'd0) fold_block();
  endtask

  task automatic restart_hash();
    for (int k = 0; k < 8; k++) chain[k] = HASH_IV[k];
    fill = '0;
    msg_len = '0;
  endtask

  // Advance the predicted hash by one accepted item; on an end-of-message
  // item pad, finish and queue the eight digest words.
  task automatic absorb_item(input msg_item_t it);
    logic [63:0] bit_len;
    dig_item_t   word;
    if (it.has_byte) begin
      place_byte(it.data_byte);
      msg_len = msg_len + 61'd1;
      bytes_hashed++;
    end
    if (it.last) begin
      bit_len = {msg_len, 3'b000};
      if (fill >= LEN_FIELD_POS) two_block_pads++;
      place_byte(PAD_BYTE);
      while (fill != LEN_FIELD_POS) place_byte(8'h00);
      for (int k = 0; k < 8; k++) place_byte(bit_len[63 - 8*k -: 8]);
      for (int k = 0; k < 8; k++) begin
        word.digest_word = chain[k];
        word.word_index  = 3'(k);
        word.last_word   = (k == 7);
        digest_q.push_back(word);
      end
      restart_hash();
      msgs_hashed++;
    end
  endtask

  task automatic push_item(input logic [7:0] data, input bit has, input bit fin,
                           input bit drain);
    send_entry_t ent;
    ent.item.data_byte = data;
    ent.item.has_byte  = has;
    ent.item.last      = fin;
    ent.drain          = drain;
    pending.push_back(ent);
    queued_count++;
  endtask

  // Queue one whole message with random bytes and the odd do-nothing item
  // mixed in. With split_end the message is closed by a byteless last item.
  task automatic queue_message(input int unsigned len, input bit drain, input bit split_end);
    bit hold_first;
    hold_first = drain;
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, hold_first);
        hold_first = 1'b0;
      end
      push_item(8'($urandom_range(0, 255)), 1'b1, (k == len - 1) && !split_end, hold_first);
      hold_first = 1'b0;
    end
    if (len == 0 || split_end) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, hold_first);
  endtask

  // Sample both handshakes at the rising edge: predict on every accepted
  // message item, check every accepted digest word against the oldest one owed.
  always @(posedge clk) begin
    msg_took <= !rst && msg_valid && !msg_stall;
    dig_took <= !rst && dig_valid && !dig_stall;
    if (!rst && msg_valid && !msg_stall) begin
      absorb_item(msg);
      accepted_count++;
    end
    if (!rst && dig_valid && !dig_stall) begin
      if (digest_q.size() == 0) begin
        report_fault($sformatf("unexpected digest word %08h index %0d last %0b",
                               dig.digest_word, dig.word_index, dig.last_word));
      end else begin
        dig_item_t want;
        want = digest_q.pop_front();
        words_checked++;
        if (dig.digest_word !== want.digest_word || dig.word_index !== want.word_index ||
            dig.last_word !== want.last_word) begin
          report_fault($sformatf("got word %08h index %0d last %0b, want %08h index %0d last %0b",
                                 dig.digest_word, dig.word_index, dig.last_word,
                                 want.digest_word, want.word_index, want.last_word));
        end
      end
    end
  end

  // Sender: hold an offered item until taken, then idle for the drawn gap
  // before offering the next. A drain entry waits until no digest word is owed.
  int unsigned send_gap = 0;
  bit          send_calm = 1'b0;
  send_entry_t head;

  always @(negedge clk) begin
    if (rst) begin
      msg_valid <= 1'b0;
    end else if (msg_valid && !msg_took) begin
      // hold the stalled item
    end else if (send_gap > 0) begin
      msg_valid <= 1'b0;
      send_gap--;
    end else if (pending.size() != 0 && !(pending[0].drain && digest_q.size() != 0)) begin
      head = pending.pop_front();
      msg <= head.item;
      msg_valid <= 1'b1;
      if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
      send_gap = send_calm ? 0 : $urandom_range(0, 9);
    end else begin
      msg_valid <= 1'b0;
    end
  end

  // Receiver: after each taken digest word, stall for a drawn number of cycles.
  int unsigned recv_wait = 0;
  bit          recv_calm = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      dig_stall <= 1'b0;
    end else begin
      if (dig_took) begin
        if ($urandom_range(0, 19) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 9);
      end
      if (recv_wait > 0) begin
        dig_stall <= 1'b1;
        recv_wait--;
      end else begin
        dig_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (msg_valid && !msg_stall) || (dig_valid && !dig_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("[%0t] stuck: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned len;
    int unsigned boundary_lens [5];
    restart_hash();
    for (int k = 0; k < 16; k++) blk[k] = '0;
    boundary_lens = '{55, 56, 63, 64, 65};

    // Directed part: empty message, short known strings, field extremes,
    // ignored bytes and do-nothing items.
    push_item(8'h00, 1'b0, 1'b1, 1'b0);      // empty message
    push_item(8'h61, 1'b1, 1'b0, 1'b0);      // "abc", last on the final byte
    push_item(8'h62, 1'b1, 1'b0, 1'b0);
    push_item(8'h63, 1'b1, 1'b1, 1'b0);
    push_item(8'hff, 1'b1, 1'b1, 1'b0);      // one byte, all ones
    push_item(8'h00, 1'b1, 1'b1, 1'b0);      // one byte, all zeros
    push_item(8'ha5, 1'b0, 1'b0, 1'b0);      // do-nothing item with a stray byte
    push_item(8'h5a, 1'b1, 1'b0, 1'b0);
    push_item(8'hff, 1'b0, 1'b0, 1'b0);      // stray byte must be ignored
    push_item(8'hc3, 1'b0, 1'b1, 1'b0);      // byteless last after one byte
    push_item(8'hff, 1'b0, 1'b1, 1'b0);      // back-to-back empty messages
    push_item(8'h00, 1'b0, 1'b1, 1'b1);

    // Random part: first hit the padding edges and the full-block case with a
    // pause for all owed words, then mostly short messages with random content.
    queue_message(55, 1'b1, 1'b0);           // padding just fits one block
    queue_message(56, 1'b0, 1'b0);           // padding spills into a second block
    queue_message(64, 1'b1, 1'b1);           // full block, then a byteless last
    while (queued_count < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) len = boundary_lens[$urandom_range(0, 4)];
      else len = $urandom_range(0, 24);
      queue_message(len, $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Wait for every item to be taken and every owed word to arrive, then
    // give the block time to show any stray output.
    while (accepted_count < queued_count) @(negedge clk);
    while (digest_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("hashed %0d messages, %0d bytes, %0d with a two-block pad",
             msgs_hashed, bytes_hashed, two_block_pads);
    $display("checked %0d digest words, %0d mismatches", words_checked, fault_count);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
